// ===== rtl/lcdw_pkg.sv =====
// Shared types and constants for the LCD command-window pixel writer.
// No dependencies; used by lcdw_window_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lcdw_pkg;

  localparam int DEF_ROW_STRIDE = 320;
  localparam int DEF_FRAME_ROWS = 240;

  localparam int BUS_W   = 16;
  localparam int INDEX_W = 17;
  localparam int COLOR_W = 24;
  localparam int POS_W   = 3;

  localparam logic [BUS_W-1:0] CMD_COLUMN_SET = 16'h002A;
  localparam logic [BUS_W-1:0] CMD_ROW_SET    = 16'h002B;
  localparam logic [BUS_W-1:0] CMD_MEM_WRITE  = 16'h002C;

  // parameter position codes
  localparam logic [POS_W-1:0] POS_NONE  = 3'd0;
  localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
  localparam logic [POS_W-1:0] POS_LAST  = 3'd4;
  localparam logic [POS_W-1:0] POS_SAT   = 3'd7;

  typedef struct packed {
    logic             is_data;
    logic [BUS_W-1:0] bus_word;
  } lcdw_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               out_of_range;
  } lcdw_out_t;

  // pixel request from the window controller to the index pipeline
  typedef struct packed {
    logic               emit;
    logic [BUS_W-1:0]   row;
    logic [BUS_W-1:0]   col;
    logic [COLOR_W-1:0] color;
  } lcdw_pix_req_t;

endpackage

`default_nettype wire

// ===== rtl/lcd_command_window_pixel_writer_unit.sv =====
// An accepted word that writes a pixel goes through every stage to the output register.
// Throughput: one bus word per cycle unless the output stalls; stages: input
// register, window/cursor update with the row multiply, index add/range check
// into the output register. Words that produce no pixel retire in the input stage.
// Reset (rst, synchronous) clears command, parameter position, window, cursor
// and all valid flags.
// Top level of the LCD command-window pixel writer; depends on lcdw_pkg and
// lcdw_window_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module lcd_command_window_pixel_writer_unit #(
  parameter int ROW_STRIDE = lcdw_pkg::DEF_ROW_STRIDE,
  parameter int FRAME_ROWS = lcdw_pkg::DEF_FRAME_ROWS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lcdw_pkg::lcdw_in_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lcdw_pkg::lcdw_out_t      out_word
);

  localparam int SW         = $clog2(ROW_STRIDE + 1);
  localparam int PW         = lcdw_pkg::BUS_W + SW;
  localparam int IW         = PW + 2;
  localparam int FRAME_SIZE = ROW_STRIDE * FRAME_ROWS;

  logic                     s1_valid;
  lcdw_pkg::lcdw_in_t       s1_word;
  lcdw_pkg::lcdw_pix_req_t  req;
  logic                     s1_consume;

  logic                       s2_valid;
  logic [PW-1:0]              s2_prod;
  logic [lcdw_pkg::BUS_W-1:0] s2_col;
  logic [lcdw_pkg::COLOR_W-1:0] s2_color;
  logic                       s2_ready;
  logic                       s3_ready;

  logic signed [IW-1:0] idx;
  logic                 bad;

  assign s3_ready   = !out_valid || out_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_consume = s1_valid && (!req.emit || s2_ready);
  assign in_ready   = !s1_valid || s1_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word <= in_word;
    end
  end

  lcdw_window_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .word    (s1_word),
    .consume (s1_consume),
    .req     (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && req.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid && req.emit) begin
      s2_prod  <= PW'(req.row) * PW'(ROW_STRIDE);
      s2_col   <= req.col;
      s2_color <= req.color;
    end
  end

  // frame index is mirrored along the row
  assign idx = $signed({2'b00, s2_prod}) + $signed(IW'(ROW_STRIDE - 1))
             - $signed(IW'(s2_col));
  assign bad = (idx < 0) || (idx >= $signed(IW'(FRAME_SIZE)));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      out_word.pixel_index  <= bad ? '0 : idx[lcdw_pkg::INDEX_W-1:0];
      out_word.pixel_color  <= s2_color;
      out_word.out_of_range <= bad;
    end
  end

`ifndef NO_ASSERTIONS
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted word did not reach input register");

  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && s2_valid |=> s2_valid)
    else $error("pending pixel dropped while output stalled");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_of_range |-> out_word.pixel_index == '0)
    else $error("out-of-range pixel carries nonzero index");

  a_color_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.pixel_color[18:16] == 3'b000 &&
                  out_word.pixel_color[9:8] == 2'b00 &&
                  out_word.pixel_color[2:0] == 3'b000)
    else $error("RGB888 padding bits not zero");
`endif

endmodule

`default_nettype wire

// ===== rtl/lcdw_window_ctrl.sv =====
// Command decoder, parameter buffer, address window and cursor.
// Depends on lcdw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdw_window_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lcdw_pkg::lcdw_in_t    word,
  input  wire logic                  consume,
  output lcdw_pkg::lcdw_pix_req_t    req
);

  logic [lcdw_pkg::BUS_W-1:0] current_command, current_command_next;
  logic [lcdw_pkg::POS_W-1:0] param_position, param_position_next;
  logic [7:0]                 param_bytes [3];
  logic [lcdw_pkg::BUS_W-1:0] column_start, column_start_next;
  logic [lcdw_pkg::BUS_W-1:0] column_end, column_end_next;
  logic [lcdw_pkg::BUS_W-1:0] row_start, row_start_next;
  logic [lcdw_pkg::BUS_W-1:0] row_end, row_end_next;
  logic [lcdw_pkg::BUS_W-1:0] cursor_column, cursor_column_next;
  logic [lcdw_pkg::BUS_W-1:0] cursor_row, cursor_row_next;

  logic                       active;
  logic                       byte_wr;
  logic [1:0]                 byte_sel;
  logic [lcdw_pkg::POS_W-1:0] pos_inc;
  logic                       last_param;
  logic                       pix_write;

  assign active     = word.is_data && (param_position != lcdw_pkg::POS_NONE);
  assign pos_inc    = (param_position < lcdw_pkg::POS_SAT) ?
                      param_position + 1'b1 : param_position;
  assign last_param = (param_position == lcdw_pkg::POS_LAST);
  // bytes one to three are kept; the fourth is used as it arrives
  assign byte_wr    = active && (param_position < lcdw_pkg::POS_LAST);
  assign byte_sel   = 2'(param_position - lcdw_pkg::POS_FIRST);
  assign pix_write  = active && (current_command == lcdw_pkg::CMD_MEM_WRITE) &&
                      (param_position == lcdw_pkg::POS_FIRST);

  always_comb begin
    req.emit  = pix_write;
    req.row   = cursor_row;
    req.col   = cursor_column;
    req.color = {word.bus_word[15:11], 3'b000,
                 word.bus_word[10:5],  2'b00,
                 word.bus_word[4:0],   3'b000};
  end

  always_comb begin
    current_command_next = current_command;
    param_position_next  = param_position;
    column_start_next    = column_start;
    column_end_next      = column_end;
    row_start_next       = row_start;
    row_end_next         = row_end;
    cursor_column_next   = cursor_column;
    cursor_row_next      = cursor_row;
    if (!word.is_data) begin
      current_command_next = word.bus_word;
      param_position_next  = lcdw_pkg::POS_FIRST;
    end else if (active) begin
      param_position_next = pos_inc;
      priority if (last_param && current_command == lcdw_pkg::CMD_COLUMN_SET) begin
        column_start_next  = {param_bytes[0], param_bytes[1]};
        column_end_next    = {param_bytes[2], word.bus_word[7:0]};
        cursor_column_next = {param_bytes[0], param_bytes[1]};
      end else if (last_param && current_command == lcdw_pkg::CMD_ROW_SET) begin
        row_start_next  = {param_bytes[0], param_bytes[1]};
        row_end_next    = {param_bytes[2], word.bus_word[7:0]};
        cursor_row_next = {param_bytes[0], param_bytes[1]};
      end else if (pix_write) begin
        param_position_next = lcdw_pkg::POS_FIRST;
        // step across the window, wrapping column then row
        if (cursor_column >= column_end) begin
          cursor_column_next = column_start;
          cursor_row_next    = (cursor_row >= row_end) ? row_start : cursor_row + 1'b1;
        end else begin
          cursor_column_next = cursor_column + 1'b1;
        end
      end else begin
        param_position_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_command <= '0;
      param_position  <= lcdw_pkg::POS_NONE;
      column_start    <= '0;
      column_end      <= '0;
      row_start       <= '0;
      row_end         <= '0;
      cursor_column   <= '0;
      cursor_row      <= '0;
    end else if (consume) begin
      current_command <= current_command_next;
      param_position  <= param_position_next;
      column_start    <= column_start_next;
      column_end      <= column_end_next;
      row_start       <= row_start_next;
      row_end         <= row_end_next;
      cursor_column   <= cursor_column_next;
      cursor_row      <= cursor_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && byte_wr) begin
      param_bytes[byte_sel] <= word.bus_word[7:0];
    end
  end

endmodule

`default_nettype wire
